// File: design/sliding_window_receive_reorder_assert.svh
// assertion macros for the receive reorder window
`ifndef SLIDING_WINDOW_RECEIVE_REORDER_ASSERT_SVH
`define SLIDING_WINDOW_RECEIVE_REORDER_ASSERT_SVH

`ifndef SYNTHESIS

`define SWRR_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define SWRR_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SWRR_IMPLY(lbl, ante, cons, msg)
`define SWRR_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: design/swrr_pkg.sv
// shared types and constants of the receive reorder window
`default_nettype none

package swrr_pkg;

	localparam int WINDOW_MAX = 32;
	localparam int MAX_LEN = 2047;

	localparam int SEQ_W = 32;
	localparam int LEN_W = 11;
	localparam int HND_W = 16;
	localparam int WIN_W = 6;
	localparam int IDX_W = $clog2(WINDOW_MAX);
	localparam int STEP_W = $clog2(WINDOW_MAX + 1);

	localparam int MOD_BITS = 4;
	localparam int MOD_STEPS = SEQ_W / MOD_BITS;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic CFG_WINDOW = 1'b0;
	localparam logic CFG_ACK_MODE = 1'b1;

	typedef enum logic [1:0] {
		KIND_DELIVER = 2'd0,
		KIND_ACK = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic {
		BK_HEAD = 1'b0,
		BK_DRAIN = 1'b1
	} back_state_t;

	typedef struct packed {
		logic is_end;
		logic [SEQ_W-1:0] seq;
		logic [LEN_W-1:0] len;
		logic [HND_W-1:0] handle;
		logic [IDX_W-1:0] idx;
	} swrr_item_t;

	typedef struct packed {
		kind_t kind;
		logic [HND_W-1:0] handle;
		logic [LEN_W-1:0] len;
		logic [SEQ_W-1:0] ack_seq;
		logic [SEQ_W-1:0] bytes;
		logic last;
	} swrr_result_t;

endpackage

`default_nettype wire

// File: design/swrr_front.sv
// front end: takes packets, drops bad ones, reduces seq modulo the window
`default_nettype none

module swrr_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic checksum_ok,
	input wire logic is_end,
	input wire logic [swrr_pkg::SEQ_W-1:0] seq,
	input wire logic [swrr_pkg::LEN_W-1:0] pay_len,
	input wire logic [swrr_pkg::HND_W-1:0] pay_handle,
	input wire logic [swrr_pkg::WIN_W-1:0] win,
	output swrr_pkg::swrr_item_t push_item,
	output logic push_valid,
	input wire logic push_ready
);
	import swrr_pkg::*;

	logic busy_q;
	logic run_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [SEQ_W-1:0] div_q;
	logic [IDX_W-1:0] rem_q;
	logic is_end_q;
	logic [SEQ_W-1:0] seq_q;
	logic [LEN_W-1:0] len_q;
	logic [HND_W-1:0] hnd_q;

	logic accept;
	logic [LEN_W-1:0] len_sat;
	logic [IDX_W-1:0] rem_d;

	assign in_stall = busy_q;
	assign accept = in_valid && !busy_q;
	assign len_sat = (pay_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : pay_len;

	// restoring remainder, MOD_BITS dividend bits per cycle
	always_comb begin
		logic [IDX_W:0] t;
		rem_d = rem_q;
		for (int k = 0; k < MOD_BITS; k++) begin
			t = {rem_d, div_q[SEQ_W-1-k]};
			if (t >= win) begin
				t = t - win;
			end
			rem_d = t[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			run_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (accept && checksum_ok) begin
				busy_q <= 1'b1;
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
					run_q <= 1'b0;
				end
			end else if (push_valid && push_ready) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && checksum_ok) begin
			div_q <= seq;
			rem_q <= '0;
			is_end_q <= is_end;
			seq_q <= seq;
			len_q <= len_sat;
			hnd_q <= pay_handle;
		end else if (run_q) begin
			div_q <= div_q << MOD_BITS;
			rem_q <= rem_d;
		end
	end

	assign push_valid = busy_q && !run_q;
	assign push_item = '{is_end: is_end_q, seq: seq_q, len: len_q, handle: hnd_q, idx: rem_q};

endmodule

`default_nettype wire

// File: design/swrr_fifo.sv
// short item queue between front and back
`default_nettype none

module swrr_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire swrr_pkg::swrr_item_t push_item,
	input wire logic push_valid,
	output logic push_ready,
	output swrr_pkg::swrr_item_t head_item,
	output logic head_valid,
	input wire logic pop
);
	import swrr_pkg::*;

	swrr_item_t entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = cnt_q != FIFO_CNT_W'(FIFO_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_item = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// File: design/swrr_back.sv
// back end: window state, slot buffer, in-order drain and result register
`default_nettype none

`include "sliding_window_receive_reorder_assert.svh"

module swrr_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire swrr_pkg::swrr_item_t head_item,
	input wire logic head_valid,
	output logic pop,
	input wire logic [swrr_pkg::WIN_W-1:0] win,
	input wire logic ack_mode,
	output logic res_valid,
	output swrr_pkg::swrr_result_t res,
	input wire logic res_stall
);
	import swrr_pkg::*;

	back_state_t st_q;
	back_state_t st_d;
	logic [SEQ_W-1:0] exp_q;
	logic [SEQ_W-1:0] total_q;
	logic [WINDOW_MAX-1:0] full_q;
	logic [LEN_W-1:0] slot_len_q [WINDOW_MAX];
	logic [HND_W-1:0] slot_hnd_q [WINDOW_MAX];
	logic [SEQ_W-1:0] v_q;
	logic [IDX_W-1:0] idx_q;
	logic [STEP_W-1:0] step_q;
	logic out_valid_q;
	swrr_result_t out_q;

	logic out_free;
	logic is_old;
	logic is_beyond;
	logic is_inorder;
	logic [SEQ_W:0] limit;
	logic slot_ready;
	logic [SEQ_W-1:0] seq_inc;
	logic [SEQ_W-1:0] v_inc;
	logic [IDX_W-1:0] idx_first;
	logic [IDX_W-1:0] idx_next;

	logic emit;
	swrr_result_t emit_res;
	logic do_clear;
	logic do_start;
	logic do_buffer;
	logic do_drain;
	logic do_finish;

	function automatic logic [IDX_W-1:0] adv_idx(input logic [SEQ_W-1:0] v,
			input logic [IDX_W-1:0] idx, input logic [WIN_W-1:0] w);
		logic [WIN_W-1:0] nxt;
		nxt = {1'b0, idx} + 1'b1;
		if (v == '0 || nxt == w) begin
			return '0;
		end
		return nxt[IDX_W-1:0];
	endfunction

	assign out_free = !out_valid_q || !res_stall;
	assign limit = {1'b0, exp_q} + {{(SEQ_W+1-WIN_W){1'b0}}, win};
	assign is_old = head_item.seq < exp_q;
	assign is_beyond = {1'b0, head_item.seq} >= limit;
	assign is_inorder = head_item.seq == exp_q;
	assign slot_ready = ({{(STEP_W-WIN_W+1){1'b0}}, step_q} < {1'b0, win}) && full_q[idx_q];
	assign seq_inc = head_item.seq + 1'b1;
	assign v_inc = v_q + 1'b1;
	assign idx_first = adv_idx(seq_inc, head_item.idx, win);
	assign idx_next = adv_idx(v_inc, idx_q, win);

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_HEAD: begin
				if (head_valid && out_free && !head_item.is_end && !is_old && !is_beyond
						&& is_inorder) begin
					st_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (out_free && !slot_ready) begin
					st_d = BK_HEAD;
				end
			end
			default: st_d = BK_HEAD;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		emit_res = '0;
		pop = 1'b0;
		do_clear = 1'b0;
		do_start = 1'b0;
		do_buffer = 1'b0;
		do_drain = 1'b0;
		do_finish = 1'b0;
		case (st_q)
			BK_HEAD: begin
				if (head_valid && out_free) begin
					if (head_item.is_end) begin
						emit = 1'b1;
						emit_res.kind = KIND_DONE;
						emit_res.bytes = total_q;
						emit_res.last = 1'b1;
						do_clear = 1'b1;
						pop = 1'b1;
					end else if (is_old) begin
						emit = ack_mode;
						emit_res.kind = KIND_ACK;
						emit_res.ack_seq = head_item.seq;
						emit_res.last = 1'b1;
						pop = 1'b1;
					end else if (is_beyond) begin
						pop = 1'b1;
					end else if (is_inorder) begin
						emit = 1'b1;
						emit_res.kind = KIND_DELIVER;
						emit_res.handle = head_item.handle;
						emit_res.len = head_item.len;
						do_start = 1'b1;
					end else begin
						emit = 1'b1;
						emit_res.kind = KIND_ACK;
						emit_res.ack_seq = ack_mode ? head_item.seq : exp_q;
						emit_res.last = 1'b1;
						do_buffer = 1'b1;
						pop = 1'b1;
					end
				end
			end
			BK_DRAIN: begin
				if (out_free) begin
					emit = 1'b1;
					if (slot_ready) begin
						emit_res.kind = KIND_DELIVER;
						emit_res.handle = slot_hnd_q[idx_q];
						emit_res.len = slot_len_q[idx_q];
						do_drain = 1'b1;
					end else begin
						emit_res.kind = KIND_ACK;
						emit_res.ack_seq = ack_mode ? head_item.seq : v_q;
						emit_res.last = 1'b1;
						do_finish = 1'b1;
						pop = 1'b1;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_HEAD;
			exp_q <= '0;
			total_q <= '0;
			full_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_free) begin
				out_valid_q <= emit;
			end
			if (do_clear) begin
				exp_q <= '0;
				total_q <= '0;
				full_q <= '0;
			end
			if (do_start) begin
				total_q <= total_q + {{(SEQ_W-LEN_W){1'b0}}, head_item.len};
			end
			if (do_buffer) begin
				full_q[head_item.idx] <= 1'b1;
			end
			if (do_drain) begin
				total_q <= total_q + {{(SEQ_W-LEN_W){1'b0}}, slot_len_q[idx_q]};
				full_q[idx_q] <= 1'b0;
			end
			if (do_finish) begin
				exp_q <= v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_res;
		end
		if (do_buffer) begin
			slot_len_q[head_item.idx] <= head_item.len;
			slot_hnd_q[head_item.idx] <= head_item.handle;
		end
		if (do_start) begin
			v_q <= seq_inc;
			idx_q <= idx_first;
			step_q <= STEP_W'(1);
		end else if (do_drain) begin
			v_q <= v_inc;
			idx_q <= idx_next;
			step_q <= step_q + 1'b1;
		end
	end

	assign res_valid = out_valid_q;
	assign res = out_q;

	`SWRR_IMPLY(a_drain_idx, st_q == BK_DRAIN, {1'b0, idx_q} < win, "drain slot outside window")
	`SWRR_IMPLY(a_drain_step, st_q == BK_DRAIN, step_q != '0 && {1'b0, step_q} <= {1'b0, win}, "drain step count out of range")
	`SWRR_NEXT(a_end_clears, do_clear, exp_q == '0 && total_q == '0 && full_q == '0, "end item left window state")
	`SWRR_NEXT(a_drain_exit, do_finish, exp_q == $past(v_q) && st_q == BK_HEAD, "drain exit did not move expected number")

endmodule

`default_nettype wire

// File: design/sliding_window_receive_reorder.sv
// before the first result, the front reduces seq in 8 modulo steps of 4 bits each
// the front stalls input while its seq modulo unit reduces a packet, until it is queued
// in-order drain: one delivered result per cycle while out_stall is low, then a final ack
// a two-entry queue lets the front reduce the next packet while the back drains
// reset: asynchronous, clears window state; window 32, ack mode 0, no clearing pass
`default_nettype none

module sliding_window_receive_reorder (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_idx,
	input wire logic [swrr_pkg::WIN_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic checksum_ok,
	input wire logic is_end,
	input wire logic [swrr_pkg::SEQ_W-1:0] seq,
	input wire logic [swrr_pkg::LEN_W-1:0] pay_len,
	input wire logic [swrr_pkg::HND_W-1:0] pay_handle,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] kind,
	output logic [swrr_pkg::HND_W-1:0] out_handle,
	output logic [swrr_pkg::LEN_W-1:0] out_len,
	output logic [swrr_pkg::SEQ_W-1:0] ack_seq,
	output logic [swrr_pkg::SEQ_W-1:0] byte_count,
	output logic last
);
	import swrr_pkg::*;

	logic [WIN_W-1:0] window_q;
	logic ack_mode_q;
	logic [WIN_W-1:0] win;

	swrr_item_t push_item;
	logic push_valid;
	logic push_ready;
	swrr_item_t head_item;
	logic head_valid;
	logic pop;
	swrr_result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_W'(WINDOW_MAX);
			ack_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_WINDOW: window_q <= cfg_data;
				CFG_ACK_MODE: ack_mode_q <= cfg_data[0];
				default: ack_mode_q <= ack_mode_q;
			endcase
		end
	end

	always_comb begin
		win = window_q;
		if (window_q == '0) begin
			win = WIN_W'(1);
		end else if (window_q > WIN_W'(WINDOW_MAX)) begin
			win = WIN_W'(WINDOW_MAX);
		end
	end

	swrr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.checksum_ok(checksum_ok),
		.is_end(is_end),
		.seq(seq),
		.pay_len(pay_len),
		.pay_handle(pay_handle),
		.win(win),
		.push_item(push_item),
		.push_valid(push_valid),
		.push_ready(push_ready)
	);

	swrr_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_item(push_item),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.head_item(head_item),
		.head_valid(head_valid),
		.pop(pop)
	);

	swrr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_item(head_item),
		.head_valid(head_valid),
		.pop(pop),
		.win(win),
		.ack_mode(ack_mode_q),
		.res_valid(out_valid),
		.res(res),
		.res_stall(out_stall)
	);

	assign kind = res.kind;
	assign out_handle = res.handle;
	assign out_len = res.len;
	assign ack_seq = res.ack_seq;
	assign byte_count = res.bytes;
	assign last = res.last;

endmodule

`default_nettype wire
